// ===== rtl/core/thrwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package thrwd_pkg;

  // Table geometry
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Operation codes
  localparam logic [2:0] OP_ENABLE  = 3'd0;
  localparam logic [2:0] OP_DISABLE = 3'd1;
  localparam logic [2:0] OP_KICK    = 3'd2;
  localparam logic [2:0] OP_SET_TMO = 3'd3;
  localparam logic [2:0] OP_GET_TMO = 3'd4;
  localparam logic [2:0] OP_CHECK   = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes and reset values
  localparam logic        REG_DEFAULT_TMO  = 1'b0;
  localparam logic        REG_MANUAL_RESET = 1'b1;
  localparam logic [31:0] DEFAULT_TMO_RST  = 32'd1000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new item and restart the scan
    logic step;    // advance the scan index
    logic hit;     // record the current slot as the hit
    logic commit;  // apply table updates and register the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic direct;  // item answered without a table scan
    logic match;   // current slot satisfies the operation
    logic last;    // current slot is the last one
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/thrwd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module thrwd_ctrl
  import thrwd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dp_sts_t   sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence load, scan and response
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.direct) begin
          state_d = S_RESP;
        end else if (sts_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = S_RESP;
        end else if (sts_i.last) begin
          state_d = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/thrwd_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module thrwd_dpath
  import thrwd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [15:0] client_id_i,
  input  wire logic [31:0] timeout_ms_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        from_isr_i,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_sts_t          sts_o,
  output logic [1:0]       status_o,
  output logic [31:0]      timeout_value_o,
  output logic             hw_kick_o,
  output logic             reset_request_o
);

  // Configuration registers
  logic [31:0] dflt_tmo_q;
  logic        man_rst_q;

  // Captured item
  logic [2:0]  op_q;
  logic [15:0] id_q;
  logic [31:0] tmo_q;
  logic [31:0] now_q;
  logic        isr_q;

  // Scan state
  logic [SLOT_W-1:0] idx_q;
  logic              hit_q;
  logic [SLOT_W-1:0] hit_idx_q;
  logic [31:0]       hit_tmo_q;

  // Slot table
  logic              slot_taken_q [SLOTS];
  logic [15:0]       slot_client_q[SLOTS];
  logic [31:0]       slot_tmo_q   [SLOTS];
  logic [31:0]       slot_kick_q  [SLOTS];

  // Result register
  logic [1:0]  status_q, status_d;
  logic [31:0] tval_q, tval_d;
  logic        kick_q, kick_d;
  logic        rst_req_q, rst_req_d;

  logic        id_zero;
  logic        cur_taken;
  logic [15:0] cur_client;
  logic [31:0] cur_tmo;
  logic [31:0] elapsed;
  logic        expired;

  // Slot write controls
  logic        wr_new, wr_clear, wr_kick, wr_tmo;
  logic [31:0] new_tmo;

  assign id_zero    = (id_q == 16'd0);
  assign cur_taken  = slot_taken_q[idx_q];
  assign cur_client = slot_client_q[idx_q];
  assign cur_tmo    = slot_tmo_q[idx_q];
  assign elapsed    = now_q - slot_kick_q[idx_q];
  assign expired    = cur_taken && (cur_client != 16'd0) && (elapsed > cur_tmo);
  assign new_tmo    = (tmo_q == 32'd0) ? dflt_tmo_q : tmo_q;

  // Decide whether the item needs a scan, and test the current slot
  always_comb begin
    sts_o.direct = 1'b0;
    sts_o.match  = 1'b0;
    sts_o.last   = (idx_q == SLOT_W'(SLOTS - 1));
    case (op_q)
      OP_ENABLE:  sts_o.match = !cur_taken;
      OP_DISABLE: begin
        sts_o.direct = id_zero;
        sts_o.match  = cur_taken && (cur_client == id_q);
      end
      OP_KICK, OP_SET_TMO, OP_GET_TMO: begin
        sts_o.direct = id_zero;
        sts_o.match  = (cur_client == id_q);
      end
      OP_CHECK:   sts_o.match = expired;
      default:    sts_o.direct = 1'b1;
    endcase
  end

  // Form the result and the table update
  always_comb begin
    status_d  = ST_OK;
    tval_d    = 32'd0;
    kick_d    = 1'b0;
    rst_req_d = 1'b0;
    wr_new    = 1'b0;
    wr_clear  = 1'b0;
    wr_kick   = 1'b0;
    wr_tmo    = 1'b0;
    case (op_q)
      OP_ENABLE: begin
        status_d = hit_q ? ST_OK : ST_LIMIT;
        wr_new   = hit_q;
      end
      OP_DISABLE: begin
        if (id_zero) begin
          status_d = ST_INVALID;
        end else if (hit_q) begin
          wr_clear = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_KICK: begin
        if (id_zero) begin
          if (isr_q) begin
            kick_d = 1'b1;
          end else begin
            status_d = ST_INVALID;
          end
        end else if (hit_q) begin
          wr_kick = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_SET_TMO: begin
        if (id_zero) begin
          status_d = ST_INVALID;
        end else if (hit_q) begin
          wr_tmo = 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_GET_TMO: begin
        if (id_zero) begin
          status_d = ST_INVALID;
        end else if (hit_q) begin
          tval_d = hit_tmo_q;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        kick_d    = !hit_q;
        rst_req_d = hit_q && man_rst_q;
      end
      default: status_d = ST_INVALID;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_tmo_q <= DEFAULT_TMO_RST;
      man_rst_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DEFAULT_TMO) begin
        dflt_tmo_q <= cfg_wdata_i;
      end else if (cfg_idx_i == REG_MANUAL_RESET) begin
        man_rst_q <= cfg_wdata_i[0];
      end
    end
  end

  // Capture the item and hold it for the whole operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      id_q  <= client_id_i;
      tmo_q <= timeout_ms_i;
      now_q <= now_ms_i;
      isr_q <= from_isr_i;
    end
  end

  // Scan index and hit record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (cmd_i.hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit) begin
      hit_idx_q <= idx_q;
      hit_tmo_q <= cur_tmo;
    end
  end

  // Update the slot at the hit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_taken_q[i]  <= 1'b0;
        slot_client_q[i] <= 16'd0;
        slot_tmo_q[i]    <= 32'd0;
        slot_kick_q[i]   <= 32'd0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit_idx_q == SLOT_W'(i)) begin
          if (wr_new) begin
            slot_taken_q[i]  <= 1'b1;
            slot_client_q[i] <= id_q;
            slot_tmo_q[i]    <= new_tmo;
            slot_kick_q[i]   <= now_q;
          end
          if (wr_clear) begin
            slot_taken_q[i]  <= 1'b0;
            slot_client_q[i] <= 16'd0;
            slot_tmo_q[i]    <= 32'd0;
            slot_kick_q[i]   <= 32'd0;
          end
          if (wr_kick) begin
            slot_kick_q[i] <= now_q;
          end
          if (wr_tmo) begin
            slot_tmo_q[i] <= tmo_q;
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= status_d;
      tval_q    <= tval_d;
      kick_q    <= kick_d;
      rst_req_q <= rst_req_d;
    end
  end

  assign status_o        = status_q;
  assign timeout_value_o = tval_q;
  assign hw_kick_o       = kick_q;
  assign reset_request_o = rst_req_q;

endmodule

`default_nettype wire

// ===== rtl/core/thread_watchdog_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Watchdog table for up to SLOTS software clients. Each transfer on the slave
// stream carries one command (enable, disable, kick, set timeout, get timeout,
// check) and yields exactly one response transfer on the master stream. A
// command is captured, then the slot table is walked one slot per cycle until
// the first matching slot or the last slot, and the result is then written
// into the output register once that register is free or being read. Commands
// with client id 0 on disable, kick and the timeout operations, and unused
// opcodes, are answered without walking the table. The slot walk reads the
// table through a single read port. A new command is taken once the previous
// response sits in the output register, even if the master side has not yet
// taken it. Configuration writes are taken at any time and should be made
// while no command is in flight.

module thread_watchdog_table
  import thrwd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // client_id[15:0], timeout_ms[47:16], now_ms[79:48]
  input  wire logic [3:0]  s_axis_tuser,  // opcode[2:0], from_isr[3]
  // Response stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // status[1:0], timeout_value[33:2], hw_kick[34],
                                          // reset_request[35], zero[39:36]
);

  ctrl_cmd_t   cmd;
  dp_sts_t     sts;
  logic [1:0]  status;
  logic [31:0] timeout_value;
  logic        hw_kick;
  logic        reset_request;

  thrwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  thrwd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (s_axis_tuser[2:0]),
    .client_id_i     (s_axis_tdata[15:0]),
    .timeout_ms_i    (s_axis_tdata[47:16]),
    .now_ms_i        (s_axis_tdata[79:48]),
    .from_isr_i      (s_axis_tuser[3]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status),
    .timeout_value_o (timeout_value),
    .hw_kick_o       (hw_kick),
    .reset_request_o (reset_request)
  );

  assign m_axis_tdata = {4'd0, reset_request, hw_kick, timeout_value, status};

endmodule

`default_nettype wire

// ===== tb/tb_thread_watchdog_table.sv =====
`timescale 1ns / 1ps

module tb_thread_watchdog_table;
  import thrwd_pkg::*;

  // Opcodes the block does not define
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int DRAIN_CYCLES    = SLOTS + 8;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] client_id;
    logic [31:0] tmo;
    logic [31:0] now;
    logic        from_isr;
  } wd_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tmo_value;
    logic        hw_kick;
    logic        reset_req;
  } wd_resp_t;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_val;
    wd_cmd_t     cmd;
    logic        known;
    wd_resp_t    resp;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;  // client_id[15:0], timeout_ms[47:16], now_ms[79:48]
  logic [3:0]  s_axis_tuser  = '0;  // opcode[2:0], from_isr[3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // status[1:0], timeout_value[33:2], hw_kick[34],
                                    // reset_request[35], zero[39:36]

  // Shadow copy of the watchdog table and its registers
  logic        shadow_taken [SLOTS];
  logic [15:0] shadow_client[SLOTS];
  logic [31:0] shadow_tmo   [SLOTS];
  logic [31:0] shadow_kick  [SLOTS];
  logic [31:0] shadow_default_tmo;
  logic        shadow_manual_rst;

  wd_resp_t pending_resp_q[$];
  dir_row_t directed_rows[$];
  int       mismatch_count = 0;
  bit       steady_flow    = 1'b0;
  logic [31:0] wall_ms     = '0;

  thread_watchdog_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Lowest-numbered slot holding the client, or -1
  function automatic int find_slot(logic [15:0] id, bit need_taken);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_client[i] == id && (!need_taken || shadow_taken[i])) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return its response
  function automatic wd_resp_t predict_response(wd_cmd_t c);
    wd_resp_t    r;
    int          hit;
    logic [31:0] tmo;
    logic [31:0] age;
    bit          expired;
    r       = '0;
    hit     = -1;
    tmo     = c.tmo;
    expired = 1'b0;
    case (c.opcode)
      OP_ENABLE: begin
        if (tmo == 0) tmo = shadow_default_tmo;
        r.status = ST_LIMIT;
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_taken[i] && hit < 0) hit = i;
        end
        if (hit >= 0) begin
          shadow_taken[hit]  = 1'b1;
          shadow_tmo[hit]    = tmo;
          shadow_kick[hit]   = c.now;
          shadow_client[hit] = c.client_id;
          r.status = ST_OK;
        end
      end
      OP_DISABLE: begin
        if (c.client_id == 0) r.status = ST_INVALID;
        else begin
          hit = find_slot(c.client_id, 1'b1);
          if (hit < 0) r.status = ST_NOT_FOUND;
          else begin
            shadow_taken[hit]  = 1'b0;
            shadow_client[hit] = '0;
            shadow_tmo[hit]    = '0;
            shadow_kick[hit]   = '0;
          end
        end
      end
      OP_KICK: begin
        if (c.client_id == 0) begin
          if (c.from_isr) r.hw_kick = 1'b1;
          else r.status = ST_INVALID;
        end else begin
          hit = find_slot(c.client_id, 1'b0);
          if (hit < 0) r.status = ST_NOT_FOUND;
          else shadow_kick[hit] = c.now;
        end
      end
      OP_SET_TMO: begin
        if (c.client_id == 0) r.status = ST_INVALID;
        else begin
          hit = find_slot(c.client_id, 1'b0);
          if (hit < 0) r.status = ST_NOT_FOUND;
          else shadow_tmo[hit] = c.tmo;
        end
      end
      OP_GET_TMO: begin
        if (c.client_id == 0) r.status = ST_INVALID;
        else begin
          hit = find_slot(c.client_id, 1'b0);
          if (hit < 0) r.status = ST_NOT_FOUND;
          else r.tmo_value = shadow_tmo[hit];
        end
      end
      OP_CHECK: begin
        // Wrapping age against each live client's timeout
        for (int i = 0; i < SLOTS; i++) begin
          age = c.now - shadow_kick[i];
          if (shadow_taken[i] && shadow_client[i] != 0 && age > shadow_tmo[i]) expired = 1'b1;
        end
        if (!expired) r.hw_kick = 1'b1;
        else if (shadow_manual_rst) r.reset_req = 1'b1;
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic wd_cmd_t mk_cmd(logic [2:0] op, logic [15:0] id, logic [31:0] tmo,
                                     logic [31:0] now, logic isr);
    wd_cmd_t c;
    c.opcode    = op;
    c.client_id = id;
    c.tmo       = tmo;
    c.now       = now;
    c.from_isr  = isr;
    return c;
  endfunction

  function automatic wd_resp_t mk_resp(logic [1:0] st, logic [31:0] tval, logic kick,
                                       logic rst);
    wd_resp_t r;
    r.status    = st;
    r.tmo_value = tval;
    r.hw_kick   = kick;
    r.reset_req = rst;
    return r;
  endfunction

  // Directed row checked against the predictor
  function automatic dir_row_t cmd_row(logic [2:0] op, logic [15:0] id, logic [31:0] tmo,
                                       logic [31:0] now, logic isr);
    dir_row_t d;
    d       = '0;
    d.cmd   = mk_cmd(op, id, tmo, now, isr);
    return d;
  endfunction

  // Directed row with the response typed in
  function automatic dir_row_t exp_row(logic [2:0] op, logic [15:0] id, logic [31:0] tmo,
                                       logic [31:0] now, logic isr, wd_resp_t resp);
    dir_row_t d;
    d       = cmd_row(op, id, tmo, now, isr);
    d.known = 1'b1;
    d.resp  = resp;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic idx, logic [31:0] val);
    dir_row_t d;
    d         = '0;
    d.is_cfg  = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = val;
    return d;
  endfunction

  // Mostly short gaps, a few long ones, none in a steady phase
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Client ids that enables hand out, so slots churn instead of leaking
  function automatic logic [15:0] pool_id();
    int k;
    k = $urandom_range(0, 11);
    if (k < 10) return 16'(k + 1);
    return (k == 10) ? 16'hFFFF : 16'h8001;
  endfunction

  function automatic wd_cmd_t random_command();
    wd_cmd_t c;
    int      r;
    r = $urandom_range(0, 99);
    if      (r < 18) c.opcode = OP_ENABLE;
    else if (r < 32) c.opcode = OP_DISABLE;
    else if (r < 56) c.opcode = OP_KICK;
    else if (r < 66) c.opcode = OP_SET_TMO;
    else if (r < 76) c.opcode = OP_GET_TMO;
    else if (r < 97) c.opcode = OP_CHECK;
    else c.opcode = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    r = $urandom_range(0, 99);
    if (c.opcode == OP_ENABLE || r < 85) c.client_id = pool_id();
    else if (r < 91) c.client_id = '0;
    else c.client_id = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if      (r < 15) c.tmo = '0;
    else if (r < 60) c.tmo = $urandom_range(1, 40);
    else if (r < 80) c.tmo = $urandom_range(41, 600);
    else if (r < 93) c.tmo = $urandom;
    else c.tmo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
    // Time mostly creeps forward, now and then it jumps
    wall_ms = wall_ms + $urandom_range(0, 8);
    c.now   = ($urandom_range(0, 99) < 92) ? wall_ms : $urandom;
    c.from_isr = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic check_response(logic [39:0] d);
    wd_resp_t e;
    if (pending_resp_q.size() == 0) begin
      $error("response transfer with none outstanding: %0h", d);
      mismatch_count++;
    end else begin
      e = pending_resp_q.pop_front();
      compare_field("status", 32'(e.status), 32'(d[1:0]));
      compare_field("timeout_value", e.tmo_value, d[33:2]);
      compare_field("hw_kick", 32'(e.hw_kick), 32'(d[34]));
      compare_field("reset_request", 32'(e.reset_req), 32'(d[35]));
      compare_field("zero pad", 32'd0, 32'(d[39:36]));
    end
  endtask

  // Offer one command, hold it until the transfer, then queue its response
  task automatic send_command(wd_cmd_t c, bit known, wd_resp_t typed);
    wd_resp_t pred;
    s_axis_tdata  <= {c.now, c.tmo, c.client_id};
    s_axis_tuser  <= {c.from_isr, c.opcode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_response(c);
    pending_resp_q.push_back(known ? typed : pred);
  endtask

  task automatic sender_gap();
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every response is back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_DEFAULT_TMO) shadow_default_tmo = val;
    else shadow_manual_rst = val[0];
  endtask

  // Response side: check each transfer, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_response(m_axis_tdata);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t    row;
    logic [31:0] dflt;
    logic [31:0] man_val;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_taken[i]  = 1'b0;
      shadow_client[i] = '0;
      shadow_tmo[i]    = '0;
      shadow_kick[i]   = '0;
    end
    shadow_default_tmo = DEFAULT_TMO_RST;
    shadow_manual_rst  = 1'b1;

    // Empty table, id 0 on each operation but enable, an unknown client, unused opcode
    directed_rows.push_back(exp_row(OP_CHECK, 16'h0, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_OK, 32'd0, 1'b1, 1'b0)));
    directed_rows.push_back(exp_row(OP_DISABLE, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                    mk_resp(ST_INVALID, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_SET_TMO, 16'h0, 32'd5, 32'h0, 1'b0,
                                    mk_resp(ST_INVALID, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_GET_TMO, 16'h0, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_INVALID, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_KICK, 16'h0, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_INVALID, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_KICK, 16'h0, 32'h0, 32'h0, 1'b1,
                                    mk_resp(ST_OK, 32'd0, 1'b1, 1'b0)));
    directed_rows.push_back(exp_row(OP_GET_TMO, 16'hFFFF, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_NOT_FOUND, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_UNUSED_7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                    mk_resp(ST_INVALID, 32'd0, 1'b0, 1'b0)));
    // Default timeout, then expiry across the wrap of the ms counter
    directed_rows.push_back(cmd_row(OP_ENABLE, 16'hFFFF, 32'h0, 32'hFFFF_FFF0, 1'b0));
    directed_rows.push_back(exp_row(OP_GET_TMO, 16'hFFFF, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_OK, 32'd1000, 1'b0, 1'b0)));
    directed_rows.push_back(exp_row(OP_CHECK, 16'h0, 32'h0, 32'h0000_03D8, 1'b0,
                                    mk_resp(ST_OK, 32'd0, 1'b1, 1'b0)));
    directed_rows.push_back(exp_row(OP_CHECK, 16'h0, 32'h0, 32'h0000_03D9, 1'b0,
                                    mk_resp(ST_OK, 32'd0, 1'b0, 1'b1)));
    directed_rows.push_back(cmd_row(OP_SET_TMO, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b0));
    directed_rows.push_back(cmd_row(OP_CHECK, 16'h0, 32'h0, 32'h0000_03D9, 1'b0));
    // Zero default, a slot lost to client 0, duplicate ids
    directed_rows.push_back(cfg_row(REG_DEFAULT_TMO, 32'h0));
    directed_rows.push_back(cmd_row(OP_ENABLE, 16'h0, 32'h0, 32'd5, 1'b0));
    directed_rows.push_back(cmd_row(OP_ENABLE, 16'h00A5, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(exp_row(OP_GET_TMO, 16'h00A5, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_OK, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(cmd_row(OP_ENABLE, 16'h00A5, 32'd7, 32'h0, 1'b0));
    // Expiry with manual reset off raises nothing
    directed_rows.push_back(cfg_row(REG_MANUAL_RESET, 32'h0));
    directed_rows.push_back(exp_row(OP_CHECK, 16'h0, 32'h0, 32'd1, 1'b0,
                                    mk_resp(ST_OK, 32'd0, 1'b0, 1'b0)));
    directed_rows.push_back(cmd_row(OP_DISABLE, 16'h00A5, 32'h0, 32'h0, 1'b0));
    directed_rows.push_back(exp_row(OP_GET_TMO, 16'h00A5, 32'h0, 32'h0, 1'b0,
                                    mk_resp(ST_OK, 32'd7, 1'b0, 1'b0)));
    // Fill the table, then one more
    for (int i = 0; i < 5; i++)
      directed_rows.push_back(cmd_row(OP_ENABLE, 16'(16'h1001 + i), 32'(50 * i), 32'd2, 1'b0));
    directed_rows.push_back(exp_row(OP_ENABLE, 16'h1006, 32'd9, 32'd2, 1'b0,
                                    mk_resp(ST_LIMIT, 32'd0, 1'b0, 1'b0)));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_register(row.cfg_idx, row.cfg_val);
      end else begin
        send_command(row.cmd, row.known, row.resp);
        sender_gap();
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: dflt = DEFAULT_TMO_RST;
        1: dflt = 32'd1;
        2: dflt = 32'hFFFF_FFFF;
        3: dflt = 32'h0;
        default: dflt = $urandom_range(0, 1) ? 32'($urandom_range(1, 64)) : $urandom;
      endcase
      man_val    = $urandom;
      man_val[0] = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      write_register(REG_DEFAULT_TMO, dflt);
      write_register(REG_MANUAL_RESET, man_val);
      steady_flow = (p == 2 || p == 5);
      if (p == 1 || p == 5) wall_ms = 32'hFFFF_FF00;
      repeat (ITEMS_PER_PHASE) begin
        send_command(random_command(), 1'b0, '0);
        sender_gap();
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog on the run itself
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/thrwd_pkg.sv
rtl/core/thrwd_ctrl.sv
rtl/core/thrwd_dpath.sv
rtl/core/thread_watchdog_table.sv
tb/tb_thread_watchdog_table.sv
